FILE: hdl/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// GNSS binary frame parser package
// Shared constants, types and the bytewise CRC-16-CCITT update.
// ----------------------------------------------------------------------------
package gbfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ApbW   = 32;
  localparam int unsigned PaddrW = 3;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'h24;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h40;

  localparam logic [WordW-1:0] CrcPoly   = 16'h1021;
  localparam logic [WordW-1:0] HdrLen    = 16'd8;
  localparam logic [WordW-1:0] FailMax   = 16'hFFFF;

  // Register index is taken from the address bit above the word offset.
  localparam logic RegSyncFirst  = 1'b0;
  localparam logic RegSyncSecond = 1'b1;

  typedef enum logic [8:0] {
    PhSync1 = 9'b000000001,
    PhSync2 = 9'b000000010,
    PhCrcLo = 9'b000000100,
    PhCrcHi = 9'b000001000,
    PhIdLo  = 9'b000010000,
    PhIdHi  = 9'b000100000,
    PhLenLo = 9'b001000000,
    PhLenHi = 9'b010000000,
    PhBody  = 9'b100000000
  } phase_e;

  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[WordW-1]) begin
        c = {c[WordW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[WordW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/gbfp_stream_if.sv
// ----------------------------------------------------------------------------
// GNSS binary frame parser channels
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface gbfp_rx_if;
  logic                       valid;
  logic                       ready;
  logic [gbfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfp_res_if;
  logic                       valid;
  logic                       ready;
  logic [gbfp_pkg::ByteW-1:0] body_byte;
  logic                       body_valid;
  logic [gbfp_pkg::WordW-1:0] body_index;
  logic                       frame_last;
  logic                       crc_ok;
  logic [gbfp_pkg::WordW-1:0] block_id;
  logic [gbfp_pkg::WordW-1:0] frame_length;
  logic [gbfp_pkg::WordW-1:0] crc_fail_count;

  modport source (output valid, output body_byte, output body_valid, output body_index,
                  output frame_last, output crc_ok, output block_id, output frame_length,
                  output crc_fail_count, input ready);
  modport sink   (input valid, input body_byte, input body_valid, input body_index,
                  input frame_last, input crc_ok, input block_id, input frame_length,
                  input crc_fail_count, output ready);
endinterface

FILE: hdl/gnss_binary_frame_parser_core.sv
// ----------------------------------------------------------------------------
// GNSS binary frame parser core
// Sync hunt, header capture, body pass-through and CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Usage: received bytes arrive one per transfer on rx_i. Each byte is consumed
// by the frame state machine; header bytes give no result, every body byte gives
// one result on res_o, and the last byte of a frame carries frame_last together
// with the CRC verdict, block id, length and the saturating failure count. A
// frame of length 8 completes on its second length byte with an empty result.
// A result is registered and presented the cycle after its byte is taken.
// Throughput is one byte per cycle, set by the single result register; a byte
// is accepted whenever that register is empty or is being emptied in the same
// cycle. When the receiver stalls, the result holds and rx_i stalls with it.
// The sync bytes are programmed over the APB port at addresses 0 and 4 and may
// only be changed while the parser is idle. Reset returns the parser to the
// sync hunt with default sync bytes, clears the failure count and empties the
// result register.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbfp_pkg::PaddrW-1:0]   paddr,
  input  logic [gbfp_pkg::ApbW-1:0]     pwdata,
  output logic [gbfp_pkg::ApbW-1:0]     prdata,
  output logic                          pready,
  gbfp_rx_if.sink                       rx_i,
  gbfp_res_if.source                    res_o
);

  logic [gbfp_pkg::ByteW-1:0] sync_first_q, sync_second_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= gbfp_pkg::SyncFirstRst;
      sync_second_q <= gbfp_pkg::SyncSecondRst;
    end else if (cfg_wr) begin
      if (paddr[2] == gbfp_pkg::RegSyncFirst) begin
        sync_first_q <= pwdata[gbfp_pkg::ByteW-1:0];
      end else begin
        sync_second_q <= pwdata[gbfp_pkg::ByteW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == gbfp_pkg::RegSyncFirst) begin
      prdata[gbfp_pkg::ByteW-1:0] = sync_first_q;
    end else begin
      prdata[gbfp_pkg::ByteW-1:0] = sync_second_q;
    end
  end

  gbfp_pkg::phase_e           phase_q, phase_d;
  logic [gbfp_pkg::WordW-1:0] rx_crc_q, rx_crc_d;
  logic [gbfp_pkg::WordW-1:0] id_q, id_d;
  logic [gbfp_pkg::WordW-1:0] len_q, len_d;
  logic [gbfp_pkg::WordW-1:0] body_len_q, body_len_d;
  logic [gbfp_pkg::WordW-1:0] count_q, count_d;
  logic [gbfp_pkg::WordW-1:0] crc_q, crc_d;
  logic [gbfp_pkg::WordW-1:0] fail_q, fail_d;

  logic                       res_valid_q;
  logic [gbfp_pkg::ByteW-1:0] r_byte_q, r_byte_d;
  logic                       r_bvalid_q, r_bvalid_d;
  logic [gbfp_pkg::WordW-1:0] r_index_q, r_index_d;
  logic                       r_last_q, r_last_d;
  logic                       r_ok_q, r_ok_d;
  logic [gbfp_pkg::WordW-1:0] r_id_q, r_id_d;
  logic [gbfp_pkg::WordW-1:0] r_len_q, r_len_d;
  logic [gbfp_pkg::WordW-1:0] r_fail_q, r_fail_d;

  logic                       take;
  logic                       emit;
  logic [gbfp_pkg::ByteW-1:0] b;
  logic [gbfp_pkg::WordW-1:0] crc_upd;
  logic [gbfp_pkg::WordW-1:0] len_full;
  logic [gbfp_pkg::WordW-1:0] count_inc;
  logic                       finish;
  logic                       ok;

  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign take       = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign crc_upd    = gbfp_pkg::crc_byte(crc_q, b);
  assign len_full   = {b, len_q[gbfp_pkg::ByteW-1:0]};
  assign count_inc  = count_q + 16'd1;
  assign ok         = (crc_upd == rx_crc_q);

  always_comb begin
    phase_d    = phase_q;
    rx_crc_d   = rx_crc_q;
    id_d       = id_q;
    len_d      = len_q;
    body_len_d = body_len_q;
    count_d    = count_q;
    crc_d      = crc_q;
    fail_d     = fail_q;
    emit       = 1'b0;
    finish     = 1'b0;
    r_byte_d   = '0;
    r_bvalid_d = 1'b0;
    r_index_d  = '0;
    unique case (phase_q)
      gbfp_pkg::PhSync1: begin
        if (b == sync_first_q) begin
          phase_d = gbfp_pkg::PhSync2;
        end
      end
      gbfp_pkg::PhSync2: begin
        phase_d = (b == sync_second_q) ? gbfp_pkg::PhCrcLo : gbfp_pkg::PhSync1;
      end
      gbfp_pkg::PhCrcLo: begin
        rx_crc_d = {8'h00, b};
        phase_d  = gbfp_pkg::PhCrcHi;
      end
      gbfp_pkg::PhCrcHi: begin
        rx_crc_d = {b, rx_crc_q[gbfp_pkg::ByteW-1:0]};
        phase_d  = gbfp_pkg::PhIdLo;
      end
      gbfp_pkg::PhIdLo: begin
        id_d    = {8'h00, b};
        crc_d   = gbfp_pkg::crc_byte('0, b);
        phase_d = gbfp_pkg::PhIdHi;
      end
      gbfp_pkg::PhIdHi: begin
        id_d    = {b, id_q[gbfp_pkg::ByteW-1:0]};
        crc_d   = crc_upd;
        phase_d = gbfp_pkg::PhLenLo;
      end
      gbfp_pkg::PhLenLo: begin
        len_d   = {8'h00, b};
        crc_d   = crc_upd;
        phase_d = gbfp_pkg::PhLenHi;
      end
      gbfp_pkg::PhLenHi: begin
        len_d      = len_full;
        crc_d      = crc_upd;
        body_len_d = len_full - gbfp_pkg::HdrLen;
        count_d    = '0;
        if ((len_full[1:0] != 2'b00) || (len_full < gbfp_pkg::HdrLen)) begin
          phase_d = gbfp_pkg::PhSync1;
        end else if (len_full != gbfp_pkg::HdrLen) begin
          phase_d = gbfp_pkg::PhBody;
        end else begin
          emit    = 1'b1;
          finish  = 1'b1;
          phase_d = gbfp_pkg::PhSync1;
        end
      end
      gbfp_pkg::PhBody: begin
        crc_d      = crc_upd;
        count_d    = count_inc;
        emit       = 1'b1;
        r_byte_d   = b;
        r_bvalid_d = 1'b1;
        r_index_d  = count_q;
        if (count_inc == body_len_q) begin
          finish  = 1'b1;
          phase_d = gbfp_pkg::PhSync1;
        end
      end
      default: begin
        phase_d = gbfp_pkg::PhSync1;
      end
    endcase
    if (finish && !ok && (fail_q != gbfp_pkg::FailMax)) begin
      fail_d = fail_q + 16'd1;
    end
    r_last_d = finish;
    r_ok_d   = finish && ok;
    r_id_d   = id_d;
    r_len_d  = len_d;
    r_fail_d = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gbfp_pkg::PhSync1;
      rx_crc_q    <= '0;
      id_q        <= '0;
      len_q       <= '0;
      body_len_q  <= '0;
      count_q     <= '0;
      crc_q       <= '0;
      fail_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q    <= phase_d;
        rx_crc_q   <= rx_crc_d;
        id_q       <= id_d;
        len_q      <= len_d;
        body_len_q <= body_len_d;
        count_q    <= count_d;
        crc_q      <= crc_d;
        fail_q     <= fail_d;
      end
      if (rx_i.ready) begin
        res_valid_q <= take && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      r_byte_q   <= r_byte_d;
      r_bvalid_q <= r_bvalid_d;
      r_index_q  <= r_index_d;
      r_last_q   <= r_last_d;
      r_ok_q     <= r_ok_d;
      r_id_q     <= r_id_d;
      r_len_q    <= r_len_d;
      r_fail_q   <= r_fail_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.body_byte      = r_byte_q;
  assign res_o.body_valid     = r_bvalid_q;
  assign res_o.body_index     = r_index_q;
  assign res_o.frame_last     = r_last_q;
  assign res_o.crc_ok         = r_ok_q;
  assign res_o.block_id       = r_id_q;
  assign res_o.frame_length   = r_len_q;
  assign res_o.crc_fail_count = r_fail_q;

endmodule
